// ----- hw/rtl/slpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slpc_pkg;

  // UI state encoding, shared with the software state write and ui_state
  typedef enum logic [2:0] {
    ST_BOOT     = 3'd0,
    ST_IDLE     = 3'd1,
    ST_ARMED    = 3'd2,
    ST_CAPTURED = 3'd3,
    ST_ERROR    = 3'd4
  } ui_state_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_LONG_PRESS_MS = 1'b0,
    CFG_COMMON_ANODE  = 1'b1
  } cfg_index_e;

  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned PRESS_BITS    = 16;
  localparam logic [PRESS_BITS-1:0] LONG_PRESS_RESET = 16'd2000;

  // In-state timer
  localparam int unsigned TIMER_BITS = 32;
  typedef logic [TIMER_BITS-1:0] timer_t;

  localparam timer_t BOOT_RED_END   = 500;
  localparam timer_t BOOT_GREEN_END = 1000;
  localparam timer_t BOOT_BLUE_END  = 1500;
  localparam timer_t BOOT_WHITE_END = 2000;
  localparam timer_t BOOT_LIMIT     = 2200;
  localparam timer_t CAPTURED_LIMIT = 1200;
  localparam timer_t ERROR_LIMIT    = 1500;

  // Blink and pulse phase counters (timer modulo the pattern period)
  localparam int unsigned IDLE_PERIOD  = 1500;
  localparam int unsigned ARMED_PERIOD = 250;
  localparam int unsigned ERROR_PERIOD = 400;
  localparam int unsigned PULSE_PERIOD = 2000;

  typedef logic [$clog2(IDLE_PERIOD)-1:0]  ph_idle_t;
  typedef logic [$clog2(ARMED_PERIOD)-1:0] ph_armed_t;
  typedef logic [$clog2(ERROR_PERIOD)-1:0] ph_error_t;
  typedef logic [$clog2(PULSE_PERIOD)-1:0] ph_pulse_t;

  localparam ph_idle_t  IDLE_HALF  = ph_idle_t'(IDLE_PERIOD / 2);
  localparam ph_idle_t  IDLE_LAST  = ph_idle_t'(IDLE_PERIOD - 1);
  localparam ph_armed_t ARMED_HALF = ph_armed_t'(ARMED_PERIOD / 2);
  localparam ph_armed_t ARMED_LAST = ph_armed_t'(ARMED_PERIOD - 1);
  localparam ph_error_t ERROR_HALF = ph_error_t'(ERROR_PERIOD / 2);
  localparam ph_error_t ERROR_LAST = ph_error_t'(ERROR_PERIOD - 1);
  localparam ph_pulse_t PULSE_HALF = ph_pulse_t'(PULSE_PERIOD / 2);
  localparam ph_pulse_t PULSE_LAST = ph_pulse_t'(PULSE_PERIOD - 1);

  // Triangle ramp: level = up * 60 / 1000 = (3 * up) / 50, up <= 1000.
  // Division by 50 is a multiply by ceil(2^17 / 50) and a shift.
  localparam int unsigned RAMP_BITS    = $clog2(PULSE_PERIOD / 2 + 1);
  localparam int unsigned TRI_X_BITS   = 12;
  localparam int unsigned TRI_SHIFT    = 17;
  localparam int unsigned TRI_RECIP    = (2 ** TRI_SHIFT + 49) / 50;
  localparam int unsigned TRI_PROD_BITS = 24;

  typedef logic [7:0] duty_t;

  typedef struct packed {
    duty_t     red;
    duty_t     green;
    duty_t     blue;
    logic      long_press;
    ui_state_e ui_state;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/status_led_pattern_controller_unit.sv -----
// Status LED pattern controller: one input transaction is one millisecond tick.
// A taken tick's result is registered in the output register, or in the skid
// register while the output stalls; this two-entry buffer lets input be taken
// while a result waits. Throughput: one transaction per clock cycle while the skid is empty.
// Reset (rst_ni low, asynchronous): state boot, timers and long-press tracking
// cleared, long_press_ms = 2000, common_anode = 0, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module status_led_pattern_controller_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_index_i,
  input  wire logic [slpc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // tick input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               state_write_i,
  input  wire logic [2:0]                         new_state_i,
  input  wire logic                               button_pressed_i,
  input  wire logic                               host_connected_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [7:0]                              red_duty_o,
  output logic [7:0]                              green_duty_o,
  output logic [7:0]                              blue_duty_o,
  output logic                                    long_press_o,
  output logic [2:0]                              ui_state_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [slpc_pkg::PRESS_BITS-1:0] long_press_ms_q;
  logic                            common_anode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ms_q <= slpc_pkg::LONG_PRESS_RESET;
      common_anode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (slpc_pkg::cfg_index_e'(cfg_index_i))
        slpc_pkg::CFG_LONG_PRESS_MS: long_press_ms_q <= cfg_data_i[slpc_pkg::PRESS_BITS-1:0];
        slpc_pkg::CFG_COMMON_ANODE:  common_anode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tick state
  // ---------------------------------------------------------------------------
  slpc_pkg::ui_state_e             state_q, state_d;
  slpc_pkg::timer_t                ms_q, ms_d;
  slpc_pkg::ph_idle_t              ph_idle_q, ph_idle_d;
  slpc_pkg::ph_armed_t             ph_armed_q, ph_armed_d;
  slpc_pkg::ph_error_t             ph_error_q, ph_error_d;
  slpc_pkg::ph_pulse_t             ph_pulse_q, ph_pulse_d;
  logic [slpc_pkg::PRESS_BITS-1:0] press_q, press_d;
  logic                            lp_done_q, lp_done_d;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // Values seen by this tick, after a state write applies
  logic                wr_ok;
  slpc_pkg::ui_state_e cur;
  slpc_pkg::timer_t    t;
  slpc_pkg::timer_t    t_inc;
  slpc_pkg::ph_idle_t  ph_idle;
  slpc_pkg::ph_armed_t ph_armed;
  slpc_pkg::ph_error_t ph_error;
  slpc_pkg::ph_pulse_t ph_pulse;
  logic                leave;
  logic                fire;

  // Triangle pulse datapath
  logic [slpc_pkg::RAMP_BITS-1:0]     ramp;
  logic [slpc_pkg::TRI_X_BITS-1:0]    tri_x;
  logic [slpc_pkg::TRI_PROD_BITS-1:0] tri_prod;
  slpc_pkg::duty_t                    tri_level;

  slpc_pkg::duty_t  red, green, blue;
  slpc_pkg::result_t res;

  always_comb begin
    // Long press: fire once per hold, press counter saturates
    fire      = 1'b0;
    press_d   = press_q;
    lp_done_d = lp_done_q;
    if (button_pressed_i) begin
      fire      = !lp_done_q && (press_q >= long_press_ms_q);
      lp_done_d = lp_done_q || fire;
      if (press_q != '1) begin
        press_d = press_q + 1'b1;
      end
    end else begin
      press_d   = '0;
      lp_done_d = 1'b0;
    end

    // A write of a different, valid state enters it with a fresh timer
    wr_ok = state_write_i
         && (new_state_i <= 3'(slpc_pkg::ST_ERROR))
         && (new_state_i != 3'(state_q));
    if (wr_ok) begin
      cur      = slpc_pkg::ui_state_e'(new_state_i);
      t        = '0;
      ph_idle  = '0;
      ph_armed = '0;
      ph_error = '0;
      ph_pulse = '0;
    end else begin
      cur      = state_q;
      t        = ms_q;
      ph_idle  = ph_idle_q;
      ph_armed = ph_armed_q;
      ph_error = ph_error_q;
      ph_pulse = ph_pulse_q;
    end

    // Triangle: ramp up over the first half of the period, down over the second
    if (ph_pulse < slpc_pkg::PULSE_HALF) begin
      ramp = slpc_pkg::RAMP_BITS'(ph_pulse);
    end else begin
      ramp = slpc_pkg::RAMP_BITS'(slpc_pkg::PULSE_PERIOD - 32'(ph_pulse));
    end
    tri_x     = slpc_pkg::TRI_X_BITS'({ramp, 1'b0}) + slpc_pkg::TRI_X_BITS'(ramp);
    tri_prod  = slpc_pkg::TRI_PROD_BITS'(tri_x)
              * slpc_pkg::TRI_PROD_BITS'(slpc_pkg::TRI_RECIP);
    tri_level = 8'(tri_prod >> slpc_pkg::TRI_SHIFT);

    // Pattern per state
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    leave = 1'b0;
    unique case (cur)
      slpc_pkg::ST_BOOT: begin
        // colour self-test: red, green, blue, white
        if (t < slpc_pkg::BOOT_RED_END) begin
          red = 8'd255;
        end else if (t < slpc_pkg::BOOT_GREEN_END) begin
          green = 8'd255;
        end else if (t < slpc_pkg::BOOT_BLUE_END) begin
          blue = 8'd255;
        end else if (t < slpc_pkg::BOOT_WHITE_END) begin
          red   = 8'd200;
          green = 8'd200;
          blue  = 8'd200;
        end
        leave = t > slpc_pkg::BOOT_LIMIT;
      end
      slpc_pkg::ST_IDLE: begin
        if (!host_connected_i) begin
          // slow blue blink, dim in the first half
          if (ph_idle >= slpc_pkg::IDLE_HALF) begin
            green = 8'd60;
            blue  = 8'd200;
          end else begin
            blue = 8'd20;
          end
        end else begin
          red   = tri_level;
          green = tri_level;
          blue  = tri_level;
        end
      end
      slpc_pkg::ST_ARMED: begin
        if (ph_armed >= slpc_pkg::ARMED_HALF) begin
          red   = 8'd220;
          green = 8'd70;
        end
      end
      slpc_pkg::ST_CAPTURED: begin
        green = 8'd220;
        leave = t > slpc_pkg::CAPTURED_LIMIT;
      end
      slpc_pkg::ST_ERROR: begin
        if (ph_error >= slpc_pkg::ERROR_HALF) begin
          red = 8'd220;
        end
        leave = t > slpc_pkg::ERROR_LIMIT;
      end
      default: ;
    endcase

    // Advance the timer, or drop back to idle on timeout. Phase counters
    // restart whenever the timer does, including its wrap to zero.
    t_inc = t + 1'b1;
    if (leave || (t_inc == '0)) begin
      ph_idle_d  = '0;
      ph_armed_d = '0;
      ph_error_d = '0;
      ph_pulse_d = '0;
    end else begin
      ph_idle_d  = (ph_idle  == slpc_pkg::IDLE_LAST)  ? '0 : ph_idle  + 1'b1;
      ph_armed_d = (ph_armed == slpc_pkg::ARMED_LAST) ? '0 : ph_armed + 1'b1;
      ph_error_d = (ph_error == slpc_pkg::ERROR_LAST) ? '0 : ph_error + 1'b1;
      ph_pulse_d = (ph_pulse == slpc_pkg::PULSE_LAST) ? '0 : ph_pulse + 1'b1;
    end
    if (leave) begin
      state_d = slpc_pkg::ST_IDLE;
      ms_d    = '0;
    end else begin
      state_d = cur;
      ms_d    = t_inc;
    end

    // Common-anode wiring: 255 - duty is the bitwise inverse
    res.red        = common_anode_q ? ~red   : red;
    res.green      = common_anode_q ? ~green : green;
    res.blue       = common_anode_q ? ~blue  : blue;
    res.long_press = fire;
    res.ui_state   = cur;
  end

  // Commit tick state only when a transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= slpc_pkg::ST_BOOT;
      ms_q       <= '0;
      ph_idle_q  <= '0;
      ph_armed_q <= '0;
      ph_error_q <= '0;
      ph_pulse_q <= '0;
      press_q    <= '0;
      lp_done_q  <= 1'b0;
    end else if (in_take) begin
      state_q    <= state_d;
      ms_q       <= ms_d;
      ph_idle_q  <= ph_idle_d;
      ph_armed_q <= ph_armed_d;
      ph_error_q <= ph_error_d;
      ph_pulse_q <= ph_pulse_d;
      press_q    <= press_d;
      lp_done_q  <= lp_done_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: output register plus skid register. Input stalls only
  // when the skid register is occupied, so a waiting result never blocks
  // the next tick.
  // ---------------------------------------------------------------------------
  logic              out_v_q, skid_v_q;
  slpc_pkg::result_t out_q, skid_q;
  logic              out_take;

  assign out_take   = out_v_q && !out_stall_i;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (in_take) begin
      if (out_v_q && out_stall_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_take) begin
      // refill from the skid register, or go empty
      out_v_q  <= skid_v_q;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      if (out_v_q && out_stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_take && skid_v_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign red_duty_o   = out_q.red;
  assign green_duty_o = out_q.green;
  assign blue_duty_o  = out_q.blue;
  assign long_press_o = out_q.long_press;
  assign ui_state_o   = 3'(out_q.ui_state);

endmodule

`default_nettype wire

// ----- hw/rtl/slpc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slpc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] red_duty_o,
  input wire logic [7:0] green_duty_o,
  input wire logic [7:0] blue_duty_o,
  input wire logic       long_press_o,
  input wire logic [2:0] ui_state_o
);

  // Remember whether the last delivered transaction carried a long press
  logic last_lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lp_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      last_lp_q <= long_press_o;
    end
  end

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_duty_o)
      && $stable(green_duty_o) && $stable(blue_duty_o)
      && $stable(long_press_o) && $stable(ui_state_o))
    else $error("stalled result changed");

  // Input stalls only while a result is buffered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Long press never fires on two ticks in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_lp_q |-> !long_press_o)
    else $error("long press fired on consecutive ticks");

  // Captured shows steady green: green is 220 (35 when inverted), red equals blue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ui_state_o == 3'(slpc_pkg::ST_CAPTURED))
      |-> (red_duty_o == blue_duty_o)
        && ((green_duty_o == 8'd220) || (green_duty_o == 8'd35)))
    else $error("captured pattern wrong");

endmodule

bind status_led_pattern_controller_unit slpc_checker u_slpc_checker (.*);

`default_nettype wire
